// ----- hdl/tcpf_pkg.sv -----
// Shared types, constants and helper functions of the true-colour pixel formatter.
`default_nettype none

package tcpf_pkg;

   // Field widths
   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned MAX_W   = 16;
   localparam int unsigned SHIFT_W = 5;
   localparam int unsigned FMT_W   = 3;
   localparam int unsigned PROD_W  = CHAN_W + MAX_W;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned COUNT_W = 3;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = MAX_W;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RED_MAX     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_MAX   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_MAX    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_SHIFT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_SHIFT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_SHIFT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPACT     = 3'd7;

   // Register reset values
   localparam logic [MAX_W-1:0]   RED_MAX_RST     = 16'd255;
   localparam logic [MAX_W-1:0]   GREEN_MAX_RST   = 16'd255;
   localparam logic [MAX_W-1:0]   BLUE_MAX_RST    = 16'd255;
   localparam logic [SHIFT_W-1:0] RED_SHIFT_RST   = 5'd0;
   localparam logic [SHIFT_W-1:0] GREEN_SHIFT_RST = 5'd8;
   localparam logic [SHIFT_W-1:0] BLUE_SHIFT_RST  = 5'd16;
   localparam logic [FMT_W-1:0]   FORMAT_RST      = 3'd5;

   // Pixel size codes (format_code[2:1]); code three behaves as 32 bits
   localparam logic [1:0] SIZE_8  = 2'd0;
   localparam logic [1:0] SIZE_16 = 2'd1;

   // Wire byte counts
   localparam logic [COUNT_W-1:0] COUNT_1 = 3'd1;
   localparam logic [COUNT_W-1:0] COUNT_2 = 3'd2;
   localparam logic [COUNT_W-1:0] COUNT_3 = 3'd3;
   localparam logic [COUNT_W-1:0] COUNT_4 = 3'd4;

   // Scale divisor
   localparam logic [PROD_W:0] CHAN_FULL = 25'd255;

   // Load enables of the four pipeline stages
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   // Output format control
   typedef struct packed {
      logic [1:0] size;
      logic       big;
      logic       compact;
      logic       drop_first;
      logic       drop_last;
   } fmt_ctrl_type;

   // Shift a 16-bit value into the 32-bit pixel word, losing bits past bit 31
   function automatic logic [WORD_W-1:0] place(input logic [MAX_W-1:0] v,
                                              input logic [SHIFT_W-1:0] sh);
      logic [WORD_W-1:0] wide;
      wide = {{(WORD_W-MAX_W){1'b0}}, v};
      return wide << sh;
   endfunction

   // Reverse the four bytes of a word
   function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

endpackage

`default_nettype wire

// ----- hdl/tcpf_if.sv -----
// Valid/ready channel interfaces for pixel requests and wire-byte responses.
`default_nettype none

interface tcpf_req_if;
   logic                         valid;
   logic                         ready;
   logic [tcpf_pkg::CHAN_W-1:0]  red_in;
   logic [tcpf_pkg::CHAN_W-1:0]  green_in;
   logic [tcpf_pkg::CHAN_W-1:0]  blue_in;

   modport source (output valid, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface tcpf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tcpf_pkg::WORD_W-1:0]   wire_bytes;
   logic [tcpf_pkg::COUNT_W-1:0]  byte_count;

   modport source (output valid, wire_bytes, byte_count, input ready);
   modport sink   (input valid, wire_bytes, byte_count, output ready);
endinterface

`default_nettype wire

// ----- hdl/true_color_pixel_formatter.sv -----
// Top level of the true-colour pixel formatter: registers, pipeline control, datapath.
//
// Usage: one RGB pixel (8 bits a channel) is a transfer on req_chan; the result on
// rsp_chan carries the wire bytes (first sent byte in bits 7:0, unused upper bytes
// zero) and their count, 1 to 4. Every pixel gives exactly one result, in order.
// The client format is set through the csr_ write port: per-channel maximum and
// shift, format code (2*size + big-endian) and the compact three-byte rule. Write
// the registers only while no pixel is in flight.
// Stages: four register stages (multiply, quotient estimate, quotient correction,
// packing and byte order); rsp valid rises once a pixel has passed all four.
// Throughput: one pixel per clock while rsp ready is high; each stage holds its
// own valid bit.
// Stalls: when rsp ready is low the full stages hold their data, empty stages
// ahead still fill, and req ready drops only once all four stages are full.
// Nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and restores the
// registers to 255/255/255, shifts 0/8/16, 32-bit big-endian, compact off.
`default_nettype none

module true_color_pixel_formatter (
   input  wire                              clock,
   input  wire                              reset,
   tcpf_req_if.sink                         req_chan,
   tcpf_rsp_if.source                       rsp_chan,
   input  wire                              csr_wr_en,
   input  wire [tcpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [tcpf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [tcpf_pkg::MAX_W-1:0]   red_max_ff, green_max_ff, blue_max_ff;
   logic [tcpf_pkg::SHIFT_W-1:0] red_shift_ff, green_shift_ff, blue_shift_ff;
   logic [tcpf_pkg::FMT_W-1:0]   format_ff;
   logic                         compact_ff;
   logic                         drop_first_ff, drop_first_in;
   logic                         drop_last_ff, drop_last_in;
   logic [tcpf_pkg::WORD_W-1:0]  mask_raw, mask_wire;
   logic [3:0]                   valid_ff, valid_in;
   logic [3:0]                   rdy;
   tcpf_pkg::stage_en_type       en;
   tcpf_pkg::fmt_ctrl_type       ctrl;
   logic [tcpf_pkg::MAX_W-1:0]   red_scaled, green_scaled, blue_scaled;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         red_max_ff     <= tcpf_pkg::RED_MAX_RST;
         green_max_ff   <= tcpf_pkg::GREEN_MAX_RST;
         blue_max_ff    <= tcpf_pkg::BLUE_MAX_RST;
         red_shift_ff   <= tcpf_pkg::RED_SHIFT_RST;
         green_shift_ff <= tcpf_pkg::GREEN_SHIFT_RST;
         blue_shift_ff  <= tcpf_pkg::BLUE_SHIFT_RST;
         format_ff      <= tcpf_pkg::FORMAT_RST;
         compact_ff     <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            tcpf_pkg::CSR_RED_MAX:     red_max_ff     <= csr_wdata;
            tcpf_pkg::CSR_GREEN_MAX:   green_max_ff   <= csr_wdata;
            tcpf_pkg::CSR_BLUE_MAX:    blue_max_ff    <= csr_wdata;
            tcpf_pkg::CSR_RED_SHIFT:   red_shift_ff   <= csr_wdata[tcpf_pkg::SHIFT_W-1:0];
            tcpf_pkg::CSR_GREEN_SHIFT: green_shift_ff <= csr_wdata[tcpf_pkg::SHIFT_W-1:0];
            tcpf_pkg::CSR_BLUE_SHIFT:  blue_shift_ff  <= csr_wdata[tcpf_pkg::SHIFT_W-1:0];
            tcpf_pkg::CSR_FORMAT:      format_ff      <= csr_wdata[tcpf_pkg::FMT_W-1:0];
            tcpf_pkg::CSR_COMPACT:     compact_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Channel mask in wire order; decides which byte the compact rule drops
   assign mask_raw = tcpf_pkg::place(red_max_ff, red_shift_ff)
                   | tcpf_pkg::place(green_max_ff, green_shift_ff)
                   | tcpf_pkg::place(blue_max_ff, blue_shift_ff);
   assign mask_wire     = format_ff[0] ? tcpf_pkg::swap32(mask_raw) : mask_raw;
   assign drop_first_in = (mask_wire[7:0] == 8'd0);
   assign drop_last_in  = (mask_wire[31:24] == 8'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_first_ff <= 1'b0;
         drop_last_ff  <= 1'b0;
      end else begin
         drop_first_ff <= drop_first_in;
         drop_last_ff  <= drop_last_in;
      end
   end

   // Pipeline flow control: a stage takes new data when empty or when it moves on
   assign rdy[3] = !valid_ff[3] || rsp_chan.ready;
   assign rdy[2] = !valid_ff[2] || rdy[3];
   assign rdy[1] = !valid_ff[1] || rdy[2];
   assign rdy[0] = !valid_ff[0] || rdy[1];

   assign en.s1 = rdy[0] && req_chan.valid;
   assign en.s2 = rdy[1] && valid_ff[0];
   assign en.s3 = rdy[2] && valid_ff[1];
   assign en.s4 = rdy[3] && valid_ff[2];

   assign valid_in[0] = rdy[0] ? req_chan.valid : valid_ff[0];
   assign valid_in[1] = rdy[1] ? valid_ff[0]    : valid_ff[1];
   assign valid_in[2] = rdy[2] ? valid_ff[1]    : valid_ff[2];
   assign valid_in[3] = rdy[3] ? valid_ff[2]    : valid_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 4'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Channel scaling, stages 1 to 3
   tcpf_chan u_red (
      .clock     (clock),
      .en        (en),
      .value     (req_chan.red_in),
      .max_value (red_max_ff),
      .scaled    (red_scaled)
   );

   tcpf_chan u_green (
      .clock     (clock),
      .en        (en),
      .value     (req_chan.green_in),
      .max_value (green_max_ff),
      .scaled    (green_scaled)
   );

   tcpf_chan u_blue (
      .clock     (clock),
      .en        (en),
      .value     (req_chan.blue_in),
      .max_value (blue_max_ff),
      .scaled    (blue_scaled)
   );

   // Packing and byte order, stage 4
   assign ctrl.size       = format_ff[2:1];
   assign ctrl.big        = format_ff[0];
   assign ctrl.compact    = compact_ff;
   assign ctrl.drop_first = drop_first_ff;
   assign ctrl.drop_last  = drop_last_ff;

   tcpf_fmt u_fmt (
      .clock        (clock),
      .load         (en.s4),
      .red_scaled   (red_scaled),
      .green_scaled (green_scaled),
      .blue_scaled  (blue_scaled),
      .red_shift    (red_shift_ff),
      .green_shift  (green_shift_ff),
      .blue_shift   (blue_shift_ff),
      .ctrl         (ctrl),
      .wire_bytes   (rsp_chan.wire_bytes),
      .byte_count   (rsp_chan.byte_count)
   );

   assign req_chan.ready = rdy[0];
   assign rsp_chan.valid = valid_ff[3];

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.byte_count == tcpf_pkg::COUNT_1 ||
                          rsp_chan.byte_count == tcpf_pkg::COUNT_2 ||
                          rsp_chan.byte_count == tcpf_pkg::COUNT_3 ||
                          rsp_chan.byte_count == tcpf_pkg::COUNT_4))
      else $error("byte count out of range");

   a_three_only_compact: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.byte_count == tcpf_pkg::COUNT_3) |-> compact_ff)
      else $error("three-byte result without compact mode");

   a_upper_bytes_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         ((rsp_chan.byte_count != tcpf_pkg::COUNT_1 || rsp_chan.wire_bytes[31:8] == 24'd0) &&
          (rsp_chan.byte_count != tcpf_pkg::COUNT_2 || rsp_chan.wire_bytes[31:16] == 16'd0) &&
          (rsp_chan.byte_count != tcpf_pkg::COUNT_3 || rsp_chan.wire_bytes[31:24] == 8'd0)))
      else $error("bytes above the byte count are not zero");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff == 4'b1111 && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while the pipeline is full and stalled");

endmodule

`default_nettype wire

// ----- hdl/tcpf_chan.sv -----
// One colour channel: multiply by the client maximum and divide by 255 over three stages.
`default_nettype none

module tcpf_chan (
   input  wire                          clock,
   input  tcpf_pkg::stage_en_type       en,
   input  wire [tcpf_pkg::CHAN_W-1:0]   value,
   input  wire [tcpf_pkg::MAX_W-1:0]    max_value,
   output logic [tcpf_pkg::MAX_W-1:0]   scaled
);

   logic [tcpf_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [tcpf_pkg::PROD_W-1:0] prod2_ff;
   logic [tcpf_pkg::MAX_W-1:0]  quot_ff, quot_in;
   logic [tcpf_pkg::MAX_W-1:0]  scaled_ff, scaled_in;
   logic [tcpf_pkg::PROD_W:0]   est_sum;
   logic [tcpf_pkg::PROD_W:0]   rem;

   // Stage 1: 8 x 16 product
   assign prod_in = tcpf_pkg::PROD_W'(value) * tcpf_pkg::PROD_W'(max_value);

   // Stage 2: quotient estimate p/256 * (1 + 1/256 + 1/65536), low by at most one
   assign est_sum = {1'b0, prod_ff}
                  + {9'b0, prod_ff[tcpf_pkg::PROD_W-1:8]}
                  + {17'b0, prod_ff[tcpf_pkg::PROD_W-1:16]};
   assign quot_in = est_sum[tcpf_pkg::PROD_W-1:8];

   // Stage 3: remainder check corrects the estimate
   assign rem = {1'b0, prod2_ff} - {1'b0, quot_ff, 8'b0}
              + {{(tcpf_pkg::PROD_W+1-tcpf_pkg::MAX_W){1'b0}}, quot_ff};
   assign scaled_in = (rem >= tcpf_pkg::CHAN_FULL) ? quot_ff + 16'd1 : quot_ff;

   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod_ff <= prod_in;
      end
      if (en.s2) begin
         prod2_ff <= prod_ff;
         quot_ff  <= quot_in;
      end
      if (en.s3) begin
         scaled_ff <= scaled_in;
      end
   end

   assign scaled = scaled_ff;

endmodule

`default_nettype wire

// ----- hdl/tcpf_fmt.sv -----
// Final stage: place the channels in the pixel word, cut it to size and order the wire bytes.
`default_nettype none

module tcpf_fmt (
   input  wire                            clock,
   input  wire                            load,
   input  wire [tcpf_pkg::MAX_W-1:0]      red_scaled,
   input  wire [tcpf_pkg::MAX_W-1:0]      green_scaled,
   input  wire [tcpf_pkg::MAX_W-1:0]      blue_scaled,
   input  wire [tcpf_pkg::SHIFT_W-1:0]    red_shift,
   input  wire [tcpf_pkg::SHIFT_W-1:0]    green_shift,
   input  wire [tcpf_pkg::SHIFT_W-1:0]    blue_shift,
   input  tcpf_pkg::fmt_ctrl_type         ctrl,
   output logic [tcpf_pkg::WORD_W-1:0]    wire_bytes,
   output logic [tcpf_pkg::COUNT_W-1:0]   byte_count
);

   logic [tcpf_pkg::WORD_W-1:0]  pix;
   logic [tcpf_pkg::WORD_W-1:0]  wire_ff, wire_in;
   logic [tcpf_pkg::COUNT_W-1:0] count_ff, count_in;

   // Pixel word
   assign pix = tcpf_pkg::place(red_scaled, red_shift)
              | tcpf_pkg::place(green_scaled, green_shift)
              | tcpf_pkg::place(blue_scaled, blue_shift);

   // Size cut, byte order and compact rule
   always_comb begin
      wire_in  = pix;
      count_in = tcpf_pkg::COUNT_4;
      case (ctrl.size)
         tcpf_pkg::SIZE_8: begin
            wire_in  = {24'b0, pix[7:0]};
            count_in = tcpf_pkg::COUNT_1;
         end
         tcpf_pkg::SIZE_16: begin
            wire_in  = ctrl.big ? {16'b0, pix[7:0], pix[15:8]} : {16'b0, pix[15:0]};
            count_in = tcpf_pkg::COUNT_2;
         end
         default: begin
            wire_in  = ctrl.big ? tcpf_pkg::swap32(pix) : pix;
            count_in = tcpf_pkg::COUNT_4;
            if (ctrl.compact && ctrl.drop_first) begin
               wire_in  = wire_in >> 8;
               count_in = tcpf_pkg::COUNT_3;
            end else if (ctrl.compact && ctrl.drop_last) begin
               wire_in  = {8'b0, wire_in[23:0]};
               count_in = tcpf_pkg::COUNT_3;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         wire_ff  <= wire_in;
         count_ff <= count_in;
      end
   end

   assign wire_bytes = wire_ff;
   assign byte_count = count_ff;

endmodule

`default_nettype wire

// ----- tb/true_color_pixel_formatter_test.sv -----
// Self-checking testbench of the true-colour pixel formatter over many client formats.
module true_color_pixel_formatter_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned N_DIRECTED    = 9;
   localparam int unsigned N_RANDOM      = 30;
   localparam int unsigned N_PHASES      = N_DIRECTED + N_RANDOM;
   localparam int unsigned PIXELS_PER_RANDOM_PHASE = 31;
   localparam int unsigned DRAIN_CYCLES  = 8;
   localparam int unsigned CYCLE_LIMIT   = 200_000;

   typedef struct packed {
      logic [tcpf_pkg::CHAN_W-1:0] red;
      logic [tcpf_pkg::CHAN_W-1:0] green;
      logic [tcpf_pkg::CHAN_W-1:0] blue;
   } rgb_pixel_type;

   typedef struct packed {
      logic [tcpf_pkg::WORD_W-1:0]  wire_bytes;
      logic [tcpf_pkg::COUNT_W-1:0] byte_count;
   } wire_pixel_type;

   typedef struct packed {
      logic [tcpf_pkg::MAX_W-1:0]   red_max;
      logic [tcpf_pkg::MAX_W-1:0]   green_max;
      logic [tcpf_pkg::MAX_W-1:0]   blue_max;
      logic [tcpf_pkg::SHIFT_W-1:0] red_shift;
      logic [tcpf_pkg::SHIFT_W-1:0] green_shift;
      logic [tcpf_pkg::SHIFT_W-1:0] blue_shift;
      logic [tcpf_pkg::FMT_W-1:0]   format_code;
      logic                         compact;
   } client_format_type;

   // Hand-picked formats: reset values first (never written), then the corner cases
   localparam client_format_type DIRECTED_FORMATS [N_DIRECTED] = '{
      '{16'd255,   16'd255,   16'd255,   5'd0,  5'd8,  5'd16, 3'd5, 1'b0},
      '{16'd7,     16'd7,     16'd3,     5'd0,  5'd3,  5'd6,  3'd1, 1'b1},
      '{16'd31,    16'd63,    16'd31,    5'd11, 5'd5,  5'd0,  3'd2, 1'b0},
      '{16'd31,    16'd63,    16'd31,    5'd11, 5'd5,  5'd0,  3'd3, 1'b1},
      '{16'd255,   16'd255,   16'd255,   5'd8,  5'd16, 5'd24, 3'd4, 1'b1},
      '{16'd255,   16'd255,   16'd255,   5'd8,  5'd16, 5'd24, 3'd5, 1'b1},
      '{16'd65535, 16'd65535, 16'd65535, 5'd0,  5'd16, 5'd31, 3'd6, 1'b1},
      '{16'd0,     16'd0,     16'd0,     5'd31, 5'd31, 5'd31, 3'd7, 1'b1},
      '{16'd65535, 16'd65535, 16'd65535, 5'd31, 5'd31, 5'd31, 3'd4, 1'b0}
   };

   logic clock = 1'b0;
   logic reset;
   logic                            csr_wr_en;
   logic [tcpf_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [tcpf_pkg::CSR_DATA_W-1:0] csr_wdata;

   tcpf_req_if req_chan ();
   tcpf_rsp_if rsp_chan ();

   true_color_pixel_formatter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rgb_pixel_type     source_pixels [$];
   wire_pixel_type    predicted_words [$];
   client_format_type client_fmt;
   int unsigned       send_idle_pct;
   int unsigned       recv_idle_pct;
   int unsigned       error_count;
   int unsigned       results_checked;
   int unsigned       count_tally [8];
   int unsigned       cycle_count;

   always #4 clock = ~clock;

   // Channel scaling: value * max / 255, rounding down
   function automatic logic [tcpf_pkg::MAX_W-1:0] scale_channel(
         input logic [tcpf_pkg::CHAN_W-1:0] value,
         input logic [tcpf_pkg::MAX_W-1:0]  max_value);
      logic [tcpf_pkg::PROD_W-1:0] product;
      product = {{tcpf_pkg::MAX_W{1'b0}}, value} * {{tcpf_pkg::CHAN_W{1'b0}}, max_value};
      return tcpf_pkg::MAX_W'(product / tcpf_pkg::PROD_W'(255));
   endfunction

   // Move a 16-bit field to its bit position; bits beyond bit 31 fall off
   function automatic logic [tcpf_pkg::WORD_W-1:0] position_field(
         input logic [tcpf_pkg::MAX_W-1:0]   value,
         input logic [tcpf_pkg::SHIFT_W-1:0] shift);
      logic [tcpf_pkg::WORD_W-1:0] widened;
      widened = {{(tcpf_pkg::WORD_W-tcpf_pkg::MAX_W){1'b0}}, value};
      return widened << shift;
   endfunction

   // Expected wire bytes and byte count for one pixel under the given format
   function automatic wire_pixel_type format_pixel(input rgb_pixel_type px,
                                                   input client_format_type f);
      logic [tcpf_pkg::WORD_W-1:0] pixel_word;
      logic [tcpf_pkg::WORD_W-1:0] swapped;
      logic [tcpf_pkg::WORD_W-1:0] chan_mask;
      logic                        big;
      wire_pixel_type              res;
      big = f.format_code[0];
      pixel_word = position_field(scale_channel(px.red, f.red_max), f.red_shift)
                 | position_field(scale_channel(px.green, f.green_max), f.green_shift)
                 | position_field(scale_channel(px.blue, f.blue_max), f.blue_shift);
      case (f.format_code[2:1])
         tcpf_pkg::SIZE_8: begin
            res.wire_bytes = {24'd0, pixel_word[7:0]};
            res.byte_count = tcpf_pkg::COUNT_1;
         end
         tcpf_pkg::SIZE_16: begin
            res.wire_bytes = big ? {16'd0, pixel_word[7:0], pixel_word[15:8]}
                                 : {16'd0, pixel_word[15:0]};
            res.byte_count = tcpf_pkg::COUNT_2;
         end
         default: begin
            // size code three falls in here too and behaves as 32 bits
            swapped = {<<8{pixel_word}};
            res.wire_bytes = big ? swapped : pixel_word;
            res.byte_count = tcpf_pkg::COUNT_4;
            if (f.compact) begin
               chan_mask = position_field(f.red_max, f.red_shift)
                         | position_field(f.green_max, f.green_shift)
                         | position_field(f.blue_max, f.blue_shift);
               swapped = {<<8{chan_mask}};
               if (big)
                  chan_mask = swapped;
               // first wire byte wins when both ends are empty
               if (chan_mask[7:0] == 8'd0) begin
                  res.wire_bytes = res.wire_bytes >> 8;
                  res.byte_count = tcpf_pkg::COUNT_3;
               end else if (chan_mask[31:24] == 8'd0) begin
                  res.wire_bytes[31:24] = 8'd0;
                  res.byte_count = tcpf_pkg::COUNT_3;
               end
            end
         end
      endcase
      return res;
   endfunction

   function automatic logic [tcpf_pkg::CHAN_W-1:0] random_channel();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return tcpf_pkg::CHAN_W'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [tcpf_pkg::MAX_W-1:0] random_max();
      case ($urandom_range(3))
         0:       return '0;
         1:       return '1;
         2:       return tcpf_pkg::MAX_W'((32'd1 << $urandom_range(1, 16)) - 1);
         default: return tcpf_pkg::MAX_W'($urandom_range(65535));
      endcase
   endfunction

   // Half the time a packed layout like a real client format, otherwise anything goes
   function automatic client_format_type random_format();
      client_format_type f;
      int unsigned       r_bits, g_bits, b_bits, base;
      if ($urandom_range(1)) begin
         r_bits = $urandom_range(1, 8);
         g_bits = $urandom_range(1, 8);
         b_bits = $urandom_range(1, 8);
         base   = 8 * $urandom_range(1);
         f.red_max   = tcpf_pkg::MAX_W'((32'd1 << r_bits) - 1);
         f.green_max = tcpf_pkg::MAX_W'((32'd1 << g_bits) - 1);
         f.blue_max  = tcpf_pkg::MAX_W'((32'd1 << b_bits) - 1);
         f.green_shift = tcpf_pkg::SHIFT_W'(base + b_bits);
         if ($urandom_range(1)) begin
            f.blue_shift = tcpf_pkg::SHIFT_W'(base);
            f.red_shift  = tcpf_pkg::SHIFT_W'(base + b_bits + g_bits);
         end else begin
            f.red_shift   = tcpf_pkg::SHIFT_W'(base);
            f.green_shift = tcpf_pkg::SHIFT_W'(base + r_bits);
            f.blue_shift  = tcpf_pkg::SHIFT_W'(base + r_bits + g_bits);
         end
         f.format_code = tcpf_pkg::FMT_W'($urandom_range(4, 7));
      end else begin
         f.red_max     = random_max();
         f.green_max   = random_max();
         f.blue_max    = random_max();
         f.red_shift   = tcpf_pkg::SHIFT_W'($urandom_range(31));
         f.green_shift = tcpf_pkg::SHIFT_W'($urandom_range(31));
         f.blue_shift  = tcpf_pkg::SHIFT_W'($urandom_range(31));
         f.format_code = tcpf_pkg::FMT_W'($urandom_range(7));
      end
      f.compact = 1'($urandom_range(1));
      return f;
   endfunction

   task automatic write_csr(input logic [tcpf_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [tcpf_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // All eight registers; unused upper data bits carry noise the block must drop
   task automatic apply_format(input client_format_type f);
      write_csr(tcpf_pkg::CSR_RED_MAX,     f.red_max);
      write_csr(tcpf_pkg::CSR_GREEN_MAX,   f.green_max);
      write_csr(tcpf_pkg::CSR_BLUE_MAX,    f.blue_max);
      write_csr(tcpf_pkg::CSR_RED_SHIFT,   {11'($urandom), f.red_shift});
      write_csr(tcpf_pkg::CSR_GREEN_SHIFT, {11'($urandom), f.green_shift});
      write_csr(tcpf_pkg::CSR_BLUE_SHIFT,  {11'($urandom), f.blue_shift});
      write_csr(tcpf_pkg::CSR_FORMAT,      {13'($urandom), f.format_code});
      write_csr(tcpf_pkg::CSR_COMPACT,     {15'($urandom), f.compact});
      client_fmt = f;
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (source_pixels.size() != 0 || req_chan.valid || predicted_words.size() != 0);
   endtask

   // Pixel driver: next pixel only once the current one has been transferred
   always @(posedge clock) begin : drive_pixels
      rgb_pixel_type next_px;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (source_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_px = source_pixels.pop_front();
            req_chan.valid    <= 1'b1;
            req_chan.red_in   <= next_px.red;
            req_chan.green_in <= next_px.green;
            req_chan.blue_in  <= next_px.blue;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Result back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Predict on each pixel transfer, check on each result transfer
   always @(posedge clock) begin : check_results
      wire_pixel_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            predicted_words.push_back(format_pixel({req_chan.red_in, req_chan.green_in,
                                                    req_chan.blue_in}, client_fmt));
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (predicted_words.size() == 0) begin
               $display("%0t unexpected result: expected none, actual %h/%0d", $time,
                        rsp_chan.wire_bytes, rsp_chan.byte_count);
               error_count++;
            end else begin
               want = predicted_words.pop_front();
               results_checked++;
               count_tally[want.byte_count]++;
               if (rsp_chan.wire_bytes !== want.wire_bytes) begin
                  $display("%0t wire_bytes mismatch: expected %h, actual %h", $time,
                           want.wire_bytes, rsp_chan.wire_bytes);
                  error_count++;
               end
               if (rsp_chan.byte_count !== want.byte_count) begin
                  $display("%0t byte_count mismatch: expected %0d, actual %0d", $time,
                           want.byte_count, rsp_chan.byte_count);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      client_format_type f;
      int unsigned       n;
      cycle_count       = 0;
      error_count       = 0;
      results_checked   = 0;
      foreach (count_tally[i]) count_tally[i] = 0;
      send_idle_pct     = 27;
      recv_idle_pct     = 81;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = tcpf_pkg::CSR_RED_MAX;
      csr_wdata         = '0;
      req_chan.valid    = 1'b0;
      req_chan.red_in   = '0;
      req_chan.green_in = '0;
      req_chan.blue_in  = '0;
      rsp_chan.ready    = 1'b0;
      client_fmt        = DIRECTED_FORMATS[0];
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int unsigned p = 0; p < N_PHASES; p++) begin
         @(negedge clock);
         // idle mix: slow receiver, then slow sender, then full rate
         if (p < N_PHASES / 3) begin
            send_idle_pct = 27;
            recv_idle_pct = 81;
         end else if (p < 2 * N_PHASES / 3) begin
            send_idle_pct = 81;
            recv_idle_pct = 27;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         f = (p < N_DIRECTED) ? DIRECTED_FORMATS[p] : random_format();
         // first phase runs on the reset values
         if (p > 0) begin
            apply_format(f);
            @(negedge clock);
         end
         if (p < N_DIRECTED) begin
            if (p == 0)
               source_pixels.push_back('{8'h00, 8'h00, 8'h00});
            source_pixels.push_back('{8'hFF, 8'hFF, 8'hFF});
            source_pixels.push_back('{8'h5A, 8'hC3, 8'h81});
         end else begin
            n = PIXELS_PER_RANDOM_PHASE;
            repeat (n)
               source_pixels.push_back('{random_channel(), random_channel(),
                                         random_channel()});
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predicted_words.size() != 0) begin
         $display("%0t %0d results never arrived", $time, predicted_words.size());
         error_count++;
      end
      $display("Checked %0d pixels over %0d client formats, %0d errors.", results_checked,
               N_PHASES, error_count);
      $display("Result sizes: %0d x1, %0d x2, %0d x3 (compact), %0d x4 bytes.",
               count_tally[1], count_tally[2], count_tally[3], count_tally[4]);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
